// ===== hdl/majority_vote_token_action_table_core_assert.svh =====
// Assertion macros used by the checker of the token action table.
`ifndef MAJORITY_VOTE_TOKEN_ACTION_TABLE_CORE_ASSERT_SVH
`define MAJORITY_VOTE_TOKEN_ACTION_TABLE_CORE_ASSERT_SVH

// Checks a property at every rising edge outside reset.
`define MVT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mvt assertion failed");

// Checks a property at every rising edge, reset included.
`define MVT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("mvt reset assertion failed");

`endif

// ===== hdl/mvt_pkg.sv =====
// Shared types and constants of the token action table.
package mvt_pkg;

  localparam int TOKEN_W  = 32;
  localparam int ACT_IN_W = 4;
  localparam int ACTION_W = 3;
  localparam int CNT_W    = 16;
  localparam int CFG_W    = 4;
  localparam int STATUS_W = 3;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_SAMPLE   = 2'd1,
    OP_FINALIZE = 2'd2,
    OP_PREDICT  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_ACTION  = 3'd1,
    ST_FULL    = 3'd2,
    ST_CONFIG  = 3'd3,
    ST_ABORTED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_RUN,
    S_FIN,
    S_DONE
  } fsm_t;

  localparam logic REG_ACTION_COUNT = 1'b0;
  localparam logic REG_FALLBACK     = 1'b1;

  typedef struct packed {
    logic                clear;
    logic                count;
    logic                alloc;
    logic                fin_start;
    logic                fin_step;
    logic                fin_done;
    logic [ACT_IN_W-1:0] act;
    logic [ACT_IN_W-1:0] fin_idx;
    logic [ACTION_W-1:0] fallback;
    logic [TOKEN_W-1:0]  token;
  } cell_ctrl_t;

endpackage

// ===== hdl/mvt_cell.sv =====
// One table entry: token, per-action saturating counts and the voted action.
module mvt_cell #(
  parameter int MAX_ACTIONS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mvt_pkg::cell_ctrl_t           ctrl,
  input  logic                          prev_used,
  output logic                          used,
  output logic                          match,
  output logic [mvt_pkg::ACTION_W-1:0]  action
);
  import mvt_pkg::*;

  localparam int AIW = $clog2(MAX_ACTIONS);

  logic                used_r, used_nxt;
  logic [TOKEN_W-1:0]  token_r;
  logic [ACTION_W-1:0] action_r;
  logic [CNT_W-1:0]    cnt_r   [MAX_ACTIONS];
  logic [CNT_W-1:0]    cnt_nxt [MAX_ACTIONS];
  logic [CNT_W-1:0]    best_n_r;
  logic [ACTION_W-1:0] best_a_r;
  logic [CNT_W-1:0]    scan_cnt;
  logic                claim;
  logic                inc;

  assign match    = used_r && (token_r == ctrl.token);
  assign claim    = ctrl.alloc && !used_r && prev_used;
  assign inc      = (ctrl.count && match) || claim;
  assign used     = used_r;
  assign action   = action_r;
  assign scan_cnt = cnt_r[ctrl.fin_idx[AIW-1:0]];

  always_comb begin
    used_nxt = used_r;
    if (ctrl.clear) begin
      used_nxt = 1'b0;
    end else if (claim) begin
      used_nxt = 1'b1;
    end
    for (int k = 0; k < MAX_ACTIONS; k++) begin
      cnt_nxt[k] = cnt_r[k];
      if (ctrl.clear) begin
        cnt_nxt[k] = '0;
      end else if (inc && (ctrl.act[AIW-1:0] == AIW'(k)) && (cnt_r[k] != '1)) begin
        cnt_nxt[k] = cnt_r[k] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      for (int k = 0; k < MAX_ACTIONS; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      used_r <= used_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      token_r  <= ctrl.token;
      action_r <= ctrl.fallback;
    end else if (ctrl.fin_done && used_r) begin
      action_r <= best_a_r;
    end
    if (ctrl.fin_start) begin
      best_n_r <= '0;
      best_a_r <= ctrl.fallback;
    end else if (ctrl.fin_step && (scan_cnt > best_n_r)) begin
      best_n_r <= scan_cnt;
      best_a_r <= ctrl.fin_idx[ACTION_W-1:0];
    end
  end

endmodule

// ===== hdl/majority_vote_token_action_table_core.sv =====
// Top level of the majority-vote token action table.
// Input beats carry an opcode on in_tuser and the token and sample action in
// in_tdata. Every accepted beat gives exactly one result beat on out_, in the
// following cycle, holding the chosen action, the hit flag, a status code and
// the number of filled entries. Clear, sample and predict beats are taken one
// per cycle while the output is not stalled: every cell compares its token and
// counts in parallel, and free cells are claimed in order along the row. An
// accepted finalize beat with a good configuration holds in_tready low while
// every cell scans its counters one action per cycle, then stores its winner.
// The result register lets a new beat enter in the cycle the previous result
// is taken; while out_tvalid is high and out_tready low, in_tready stays low.
// Configuration is to be written through cfg_we, cfg_index and cfg_wdata only
// while the block is idle; the block does not enforce it. Synchronous reset
// empties the table, zeroes every counter, drops the abort flag and restores
// action_count 2 and fallback_action 0; no clearing pass is needed.
module majority_vote_token_action_table_core #(
  parameter  int MAX_ENTRIES = 64,
  parameter  int MAX_ACTIONS = 8,
  localparam int EW          = $clog2(MAX_ENTRIES + 1),
  localparam int OUT_W       = ((7 + EW + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [39:0]               in_tdata,   // token[31:0], sample_action[35:32]
  input  logic [1:0]                in_tuser,   // opcode[1:0]
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_W-1:0]          out_tdata,  // chosen_action, hit, status, entries_used
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [mvt_pkg::CFG_W-1:0] cfg_wdata
);
  import mvt_pkg::*;

  localparam logic [CFG_W:0] MAX_ACT_C = (CFG_W + 1)'(MAX_ACTIONS);

  logic [ACT_IN_W-1:0] action_count_r;
  logic [ACTION_W-1:0] fallback_r;
  logic                aborted_r, aborted_nxt;
  logic [EW-1:0]       total_r, total_nxt;
  fsm_t                state_r, state_nxt;
  logic [ACT_IN_W-1:0] fin_idx_r, fin_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r;

  op_t                 op;
  logic [TOKEN_W-1:0]  tok;
  logic [ACT_IN_W-1:0] act;
  logic                acc;
  logic                cfg_bad;
  logic                found;
  logic                full;
  logic [ACTION_W-1:0] hit_act;
  cell_ctrl_t          ctrl;
  status_t             status;
  logic [ACTION_W-1:0] chosen;
  logic                hit;

  logic [MAX_ENTRIES-1:0] used_vec;
  logic [MAX_ENTRIES-1:0] match_vec;
  logic [ACTION_W-1:0]    act_vec [MAX_ENTRIES];

  assign op  = op_t'(in_tuser);
  assign tok = in_tdata[TOKEN_W-1:0];
  assign act = in_tdata[TOKEN_W +: ACT_IN_W];

  assign in_tready  = (state_r == S_RUN) && (!out_valid_r || out_tready);
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cfg_bad = (action_count_r == '0) || ({1'b0, action_count_r} > MAX_ACT_C) ||
                   ({1'b0, fallback_r} >= action_count_r);
  assign found   = |match_vec;
  assign full    = used_vec[MAX_ENTRIES-1];

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    mvt_cell #(.MAX_ACTIONS(MAX_ACTIONS)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .prev_used ((i == 0) ? 1'b1 : used_vec[(i == 0) ? 0 : i-1]),
      .used      (used_vec[i]),
      .match     (match_vec[i]),
      .action    (act_vec[i])
    );
  end

  always_comb begin
    hit_act = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_act = hit_act | (act_vec[i] & {ACTION_W{match_vec[i]}});
    end
  end

  always_comb begin
    ctrl          = '0;
    ctrl.act      = act;
    ctrl.token    = tok;
    ctrl.fallback = fallback_r;
    ctrl.fin_idx  = fin_idx_r;
    status        = ST_OK;
    chosen        = '0;
    hit           = 1'b0;
    aborted_nxt   = aborted_r;
    total_nxt     = total_r;
    state_nxt     = state_r;
    fin_idx_nxt   = fin_idx_r;
    case (state_r)
      S_RUN: begin
        if (acc) begin
          case (op)
            OP_CLEAR: begin
              ctrl.clear  = 1'b1;
              total_nxt   = '0;
              aborted_nxt = cfg_bad;
              status      = cfg_bad ? ST_CONFIG : ST_OK;
            end
            OP_SAMPLE: begin
              if (aborted_r) begin
                status = ST_ABORTED;
              end else if (cfg_bad) begin
                aborted_nxt = 1'b1;
                status      = ST_CONFIG;
              end else if (act >= action_count_r) begin
                aborted_nxt = 1'b1;
                status      = ST_ACTION;
              end else if (found) begin
                ctrl.count = 1'b1;
              end else if (full) begin
                aborted_nxt = 1'b1;
                status      = ST_FULL;
              end else begin
                ctrl.alloc = 1'b1;
                total_nxt  = EW'(total_r + 1'b1);
              end
            end
            OP_FINALIZE: begin
              if (aborted_r) begin
                status = ST_ABORTED;
              end else if (cfg_bad) begin
                aborted_nxt = 1'b1;
                status      = ST_CONFIG;
              end else begin
                ctrl.fin_start = 1'b1;
                fin_idx_nxt    = '0;
                state_nxt      = S_FIN;
              end
            end
            OP_PREDICT: begin
              hit    = found;
              chosen = found ? hit_act : fallback_r;
            end
            default: begin
              status = ST_OK;
            end
          endcase
        end
      end
      S_FIN: begin
        ctrl.fin_step = 1'b1;
        if (fin_idx_r == (action_count_r - 1'b1)) begin
          state_nxt = S_DONE;
        end else begin
          fin_idx_nxt = fin_idx_r + 1'b1;
        end
      end
      S_DONE: begin
        ctrl.fin_done = 1'b1;
        state_nxt     = S_RUN;
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      action_count_r <= 4'd2;
      fallback_r     <= '0;
      aborted_r      <= 1'b0;
      total_r        <= '0;
      state_r        <= S_RUN;
      fin_idx_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == REG_ACTION_COUNT)) begin
        action_count_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == REG_FALLBACK)) begin
        fallback_r <= cfg_wdata[ACTION_W-1:0];
      end
      aborted_r   <= aborted_nxt;
      total_r     <= total_nxt;
      state_r     <= state_nxt;
      fin_idx_r   <= fin_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= OUT_W'({total_nxt, status, hit, chosen});
    end
  end

endmodule

// ===== hdl/mvt_checker.sv =====
// Port-level checker for the token action table, bound to the top level.
`include "majority_vote_token_action_table_core_assert.svh"

module mvt_checker #(
  parameter  int MAX_ENTRIES = 64,
  localparam int EW          = $clog2(MAX_ENTRIES + 1),
  localparam int OUT_W       = ((7 + EW + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);
  import mvt_pkg::*;

  localparam logic [EW-1:0] MAX_E_C = EW'(MAX_ENTRIES);

  logic [STATUS_W-1:0] st_f;
  logic [EW-1:0]       used_f;

  assign st_f   = out_tdata[6:4];
  assign used_f = out_tdata[7 +: EW];

  `MVT_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid)
  `MVT_ASSERT(a_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `MVT_ASSERT(a_used_range, out_tvalid |-> used_f <= MAX_E_C)
  `MVT_ASSERT(a_hit_ok, out_tvalid && out_tdata[3] |-> st_f == ST_OK)
  `MVT_ASSERT(a_status_range, out_tvalid |-> st_f <= ST_ABORTED)

endmodule

bind majority_vote_token_action_table_core mvt_checker #(
  .MAX_ENTRIES(MAX_ENTRIES)
) u_mvt_checker (.*);

// ===== tb/majority_vote_token_action_table_core_test.sv =====
// Self-checking testbench for the majority-vote token action table core.
module majority_vote_token_action_table_core_test;
  import mvt_pkg::*;

  localparam int ENTRIES     = 64;
  localparam int ACTIONS     = 8;
  localparam int CYCLE_LIMIT = 250000;

  typedef struct {
    op_t         op;
    logic [31:0] token;
    logic [3:0]  act;
  } beat_t;

  typedef struct packed {
    logic [6:0] used;
    logic [2:0] status;
    logic       hit;
    logic [2:0] chosen;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [3:0]  cfg_wdata = '0;

  majority_vote_token_action_table_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  logic [31:0] tok_tab [ENTRIES];
  logic [15:0] vote_cnt [ENTRIES][ACTIONS];
  logic [2:0]  tok_action [ENTRIES];
  int          filled = 0;
  bit          aborted = 1'b0;
  logic [3:0]  n_actions = 4'd2;
  logic [2:0]  dflt_action = 3'd0;

  beat_t    queued_beats[$];
  verdict_t due_results[$];
  beat_t    cur_beat;
  verdict_t got;
  verdict_t want;
  bit       in_took = 1'b0;
  bit       out_took = 1'b0;
  int       in_gap = 0;
  int       out_stall = 0;
  bit       calm = 1'b0;
  int       cycle_no = 0;
  int       fail_count = 0;
  int       op_seen [4] = '{0, 0, 0, 0};
  int       hit_count = 0;
  int       refused_count = 0;

  function automatic bit cfg_is_bad();
    return n_actions == 4'd0 || n_actions > ACTIONS || {1'b0, dflt_action} >= n_actions;
  endfunction

  function automatic int find_token(logic [31:0] t);
    for (int i = 0; i < filled; i++) begin
      if (tok_tab[i] == t) return i;
    end
    return -1;
  endfunction

  function automatic verdict_t vote_step(beat_t b);
    verdict_t    r;
    int          slot;
    logic [15:0] best_n;
    logic [2:0]  best_a;
    r = '0;
    r.status = ST_OK;
    case (b.op)
      OP_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++)
          for (int a = 0; a < ACTIONS; a++) vote_cnt[i][a] = '0;
        filled = 0;
        aborted = 1'b0;
        if (cfg_is_bad()) begin
          aborted = 1'b1;
          r.status = ST_CONFIG;
        end
      end
      OP_SAMPLE: begin
        if (aborted) begin
          r.status = ST_ABORTED;
        end else if (cfg_is_bad()) begin
          aborted = 1'b1;
          r.status = ST_CONFIG;
        end else if (b.act >= n_actions) begin
          aborted = 1'b1;
          r.status = ST_ACTION;
        end else begin
          slot = find_token(b.token);
          if (slot < 0 && filled >= ENTRIES) begin
            aborted = 1'b1;
            r.status = ST_FULL;
          end else begin
            if (slot < 0) begin
              slot = filled;
              filled++;
              tok_tab[slot] = b.token;
              tok_action[slot] = dflt_action;
            end
            if (vote_cnt[slot][b.act] != 16'hFFFF) vote_cnt[slot][b.act]++;
          end
        end
      end
      OP_FINALIZE: begin
        if (aborted) begin
          r.status = ST_ABORTED;
        end else if (cfg_is_bad()) begin
          aborted = 1'b1;
          r.status = ST_CONFIG;
        end else begin
          for (int i = 0; i < filled; i++) begin
            best_n = '0;
            best_a = dflt_action;
            for (int a = 0; a < n_actions; a++) begin
              if (vote_cnt[i][a] > best_n) begin
                best_n = vote_cnt[i][a];
                best_a = a[2:0];
              end
            end
            tok_action[i] = best_a;
          end
        end
      end
      default: begin
        slot = find_token(b.token);
        if (slot >= 0) begin
          r.chosen = tok_action[slot];
          r.hit = 1'b1;
        end else begin
          r.chosen = dflt_action;
        end
      end
    endcase
    r.used = filled[6:0];
    return r;
  endfunction

  function automatic int pick_gap();
    if (calm) return 0;
    return $urandom_range(0, 16);
  endfunction

  task automatic flag(string what, int want_v, int got_v);
    fail_count++;
    $error("%s: expected %0d, got %0d", what, want_v, got_v);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_took) begin
      in_tvalid <= 1'b1;
    end else if (in_gap > 0) begin
      in_tvalid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (queued_beats.size() > 0) begin
      cur_beat = queued_beats.pop_front();
      in_tvalid <= 1'b1;
      in_tdata <= {4'b0000, cur_beat.act, cur_beat.token};
      in_tuser <= cur_beat.op;
      if ($urandom_range(0, 39) == 0) calm = !calm;
      in_gap <= pick_gap();
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_took) out_stall = pick_gap();
      if (out_stall > 0) begin
        out_tready <= 1'b0;
        out_stall = out_stall - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    in_took <= in_tvalid && in_tready;
    out_took <= out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[13:0];
      if (due_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 30) $error("result beat arrived with no prediction pending");
      end else begin
        want = due_results.pop_front();
        if (got.chosen !== want.chosen)
          flag("chosen_action", int'(want.chosen), int'(got.chosen));
        if (got.hit !== want.hit) flag("hit", int'(want.hit), int'(got.hit));
        if (got.status !== want.status) flag("status", int'(want.status), int'(got.status));
        if (got.used !== want.used) flag("entries_used", int'(want.used), int'(got.used));
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      want = vote_step(cur_beat);
      due_results.push_back(want);
      op_seen[cur_beat.op]++;
      if (want.hit) hit_count++;
      if (want.status != ST_OK) refused_count++;
    end
    if (cycle_no >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_no);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic queue_beat(op_t op, logic [31:0] tok, logic [3:0] act);
    beat_t b;
    b.op = op;
    b.token = tok;
    b.act = act;
    queued_beats.push_back(b);
  endtask

  task automatic drain();
    while (queued_beats.size() != 0 || in_tvalid || due_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic configure(logic [3:0] count, logic [2:0] fallback);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_ACTION_COUNT;
    cfg_wdata <= count;
    n_actions = count;
    @(negedge clk);
    cfg_index <= REG_FALLBACK;
    cfg_wdata <= {1'b0, fallback};
    dflt_action = fallback;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_token();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [3:0] legal_act();
    if (n_actions == 4'd0 || n_actions > ACTIONS || $urandom_range(0, 59) == 0)
      return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, n_actions - 1));
  endfunction

  initial begin
    logic [31:0] pool[$];
    logic [31:0] tok;
    int          random_beats;
    int          pick;
    int          pool_n;
    int          len;
    logic [3:0]  n;
    random_beats = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_beat(OP_PREDICT, 32'h1234_5678, 4'd0);
    queue_beat(OP_CLEAR, 32'h0, 4'd0);
    queue_beat(OP_SAMPLE, 32'h0000_0000, 4'd0);
    queue_beat(OP_SAMPLE, 32'h7FFF_FFFF, 4'd1);
    queue_beat(OP_SAMPLE, 32'h8000_0000, 4'd1);
    queue_beat(OP_SAMPLE, 32'hFFFF_FFFF, 4'd0);
    queue_beat(OP_SAMPLE, 32'h0000_0000, 4'd1);
    queue_beat(OP_PREDICT, 32'h7FFF_FFFF, 4'd0);
    queue_beat(OP_FINALIZE, 32'h0, 4'd0);
    queue_beat(OP_PREDICT, 32'h0000_0000, 4'd0);
    queue_beat(OP_PREDICT, 32'h7FFF_FFFF, 4'd15);
    queue_beat(OP_PREDICT, 32'h8000_0000, 4'd0);
    queue_beat(OP_PREDICT, 32'hFFFF_FFFF, 4'd0);
    queue_beat(OP_PREDICT, 32'h5555_5555, 4'd0);
    queue_beat(OP_SAMPLE, 32'h0000_0001, 4'd2);
    queue_beat(OP_SAMPLE, 32'h0000_0001, 4'd0);
    queue_beat(OP_FINALIZE, 32'h0, 4'd0);
    queue_beat(OP_PREDICT, 32'h7FFF_FFFF, 4'd0);
    queue_beat(OP_CLEAR, 32'hFFFF_FFFF, 4'd15);
    queue_beat(OP_SAMPLE, 32'hAAAA_AAAA, 4'd15);
    drain();

    configure(4'd8, 3'd7);
    queue_beat(OP_CLEAR, 32'h0, 4'd0);
    queue_beat(OP_SAMPLE, 32'hCAFE_F00D, 4'd7);
    queue_beat(OP_SAMPLE, 32'hCAFE_F00D, 4'd3);
    queue_beat(OP_FINALIZE, 32'h0, 4'd0);
    queue_beat(OP_PREDICT, 32'hCAFE_F00D, 4'd0);
    drain();
    // Shrinking the action range leaves this entry without a valid vote.
    configure(4'd2, 3'd1);
    queue_beat(OP_FINALIZE, 32'h0, 4'd0);
    queue_beat(OP_PREDICT, 32'hCAFE_F00D, 4'd0);
    drain();
    configure(4'd0, 3'd1);
    queue_beat(OP_PREDICT, 32'h0BAD_0BAD, 4'd0);
    queue_beat(OP_SAMPLE, 32'hCAFE_F00D, 4'd0);
    drain();
    configure(4'd9, 3'd0);
    queue_beat(OP_CLEAR, 32'h0, 4'd0);
    queue_beat(OP_FINALIZE, 32'h0, 4'd0);
    drain();
    configure(4'd3, 3'd0);
    queue_beat(OP_CLEAR, 32'h0, 4'd0);
    queue_beat(OP_SAMPLE, 32'h0000_0042, 4'd2);
    drain();
    configure(4'd3, 3'd5);
    queue_beat(OP_FINALIZE, 32'h0, 4'd0);
    queue_beat(OP_PREDICT, 32'h0000_0042, 4'd0);
    drain();

    configure(4'd4, 3'd2);
    queue_beat(OP_CLEAR, 32'h0, 4'd0);
    for (int i = 0; i < ENTRIES; i++) queue_beat(OP_SAMPLE, 32'hC000_0000 + i, 4'(i % 4));
    queue_beat(OP_PREDICT, 32'hC000_0005, 4'd0);
    queue_beat(OP_SAMPLE, 32'hD000_0000, 4'd1);
    queue_beat(OP_SAMPLE, 32'hC000_0000, 4'd1);
    queue_beat(OP_FINALIZE, 32'h0, 4'd0);
    drain();

    while (random_beats < 700) begin
      drain();
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        configure(($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15)),
                  3'($urandom_range(0, 7)));
      end else if (pick == 1) begin
        n = 4'($urandom_range(1, 7));
        configure(n, 3'($urandom_range(n, 7)));
      end else begin
        n = 4'($urandom_range(1, 8));
        configure(n, 3'($urandom_range(0, n - 1)));
      end
      if (pool.size() == 0 || $urandom_range(0, 4) != 0) begin
        queue_beat(OP_CLEAR, $urandom, 4'($urandom_range(0, 15)));
        random_beats++;
        pool.delete();
        pool_n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
        repeat (pool_n) pool.push_back(pick_token());
        if (pool_n >= 60) begin
          foreach (pool[k]) queue_beat(OP_SAMPLE, pool[k], legal_act());
          random_beats += pool_n;
        end
      end
      len = $urandom_range(20, 50);
      repeat (len) begin
        pick = $urandom_range(0, 99);
        tok = pool[$urandom_range(0, pool.size() - 1)];
        if (pick < 55)
          queue_beat(OP_SAMPLE, tok, legal_act());
        else if (pick < 63)
          queue_beat(OP_FINALIZE, $urandom, 4'($urandom_range(0, 15)));
        else if (pick < 88)
          queue_beat(OP_PREDICT, ($urandom_range(0, 3) == 0) ? pick_token() : tok,
                     4'($urandom_range(0, 15)));
        else
          queue_beat(op_t'($urandom_range(0, 3)), pick_token(), 4'($urandom_range(0, 15)));
      end
      random_beats += len;
    end
    drain();
    repeat (20) @(posedge clk);
    if (due_results.size() != 0) begin
      fail_count++;
      $error("%0d predicted results never arrived", due_results.size());
    end

    $display("Covered %0d clear, %0d sample, %0d finalize and %0d predict beats;",
             op_seen[OP_CLEAR], op_seen[OP_SAMPLE], op_seen[OP_FINALIZE], op_seen[OP_PREDICT]);
    $display("%0d predictions hit a stored token and %0d commands were refused.",
             hit_count, refused_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
